### rtl/pwfr_pkg.sv
package pwfr_pkg;

	// frame shift register length
	localparam int FRAME_BITS = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RUNT_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT    = 2'd2;

	localparam logic [7:0] RUNT_LIMIT_RST    = 8'd5;
	localparam logic [7:0] ONE_THRESHOLD_RST = 8'd50;
	localparam logic [7:0] LONG_LIMIT_RST    = 8'd220;

	// reply table
	localparam int NUM_ROWS   = 11;
	localparam int ROW_W      = $clog2(NUM_ROWS);
	localparam int MAX_WORDS  = 4;
	localparam int WIDX_W     = $clog2(MAX_WORDS);
	localparam int CNT_W      = $clog2(MAX_WORDS + 1);

	localparam logic [31:0] ROW_KEY [NUM_ROWS] = '{
		32'h0000_E704, 32'h0000_E70E, 32'h0000_E70D, 32'h0000_E716,
		32'h0000_E715, 32'h0000_E71A, 32'h0000_39C7, 32'h0000_E71C,
		32'h0000_E71F, 32'h0003_9B82, 32'h0000_0E72
	};

	localparam logic [CNT_W-1:0] ROW_CNT [NUM_ROWS] = '{
		3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2
	};

	localparam logic [23:0] ROW_WORD [NUM_ROWS][MAX_WORDS] = '{
		'{24'hC31082, 24'hC3108B, 24'h000000, 24'h000000},
		'{24'h30C602, 24'h30C064, 24'h30C075, 24'h000000},
		'{24'h30C602, 24'h30C064, 24'h30C075, 24'h000000},
		'{24'h30C692, 24'h0C301C, 24'h30C703, 24'h0C301F},
		'{24'h30C68A, 24'h0C301C, 24'h30C703, 24'h0C301F},
		'{24'h30C613, 24'h0C301C, 24'h30C643, 24'h000000},
		'{24'h30C60B, 24'h0C301C, 24'h30C643, 24'h000000},
		'{24'h0C305D, 24'h30C643, 24'h000000, 24'h000000},
		'{24'h030C26, 24'h000000, 24'h000000, 24'h000000},
		'{24'h0C309D, 24'h000000, 24'h000000, 24'h000000},
		'{24'h30C075, 24'h30C064, 24'h000000, 24'h000000}
	};

	localparam logic [4:0] ROW_TOP [NUM_ROWS][MAX_WORDS] = '{
		'{5'd23, 5'd23, 5'd0,  5'd0 },
		'{5'd21, 5'd21, 5'd21, 5'd0 },
		'{5'd21, 5'd21, 5'd21, 5'd0 },
		'{5'd21, 5'd19, 5'd21, 5'd19},
		'{5'd21, 5'd19, 5'd21, 5'd19},
		'{5'd21, 5'd19, 5'd21, 5'd0 },
		'{5'd21, 5'd19, 5'd21, 5'd0 },
		'{5'd19, 5'd21, 5'd0,  5'd0 },
		'{5'd17, 5'd0,  5'd0,  5'd0 },
		'{5'd19, 5'd0,  5'd0,  5'd0 },
		'{5'd21, 5'd21, 5'd0,  5'd0 }
	};

	// frame queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic [7:0] runt_limit;
		logic [7:0] one_threshold;
		logic [7:0] long_limit;
	} cfg_t;

	// one closed frame that matched a table row
	typedef struct packed {
		logic vld;
		row_t row;
	} frame_ev_t;

	// queue status toward the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// table lookup of a closed frame word
	function automatic frame_ev_t lookup(logic [FRAME_BITS-1:0] frame);
		frame_ev_t ev;
		ev.vld = 1'b0;
		ev.row = '0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (FRAME_BITS'(ROW_KEY[r]) == frame &&
			    32'(FRAME_BITS'(ROW_KEY[r])) == ROW_KEY[r]) begin
				ev.vld = 1'b1;
				ev.row = ROW_W'(r);
			end
		end
		return ev;
	endfunction

endpackage

### rtl/pwfr_front.sv
module pwfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  pwfr_pkg::cfg_t    cfg,
	input  logic              pulse_valid,
	output logic              pulse_ready,
	input  logic [7:0]        pulse_ticks,
	input  pwfr_pkg::q_stat_t q_stat,
	output pwfr_pkg::frame_ev_t push
);
	import pwfr_pkg::*;

	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic                  idle_q, idle_d;
	logic                  accept;
	logic                  is_runt, is_zero, is_one, is_long;
	frame_ev_t             hit;

	assign pulse_ready = !q_stat.full;
	assign accept      = pulse_valid && pulse_ready;

	assign is_runt = pulse_ticks <= cfg.runt_limit;
	assign is_zero = pulse_ticks > cfg.runt_limit && pulse_ticks < cfg.one_threshold;
	assign is_one  = pulse_ticks >= cfg.one_threshold && pulse_ticks < cfg.long_limit;
	assign is_long = pulse_ticks >= cfg.long_limit;

	assign hit = lookup(shift_q);

	always_comb begin
		shift_d  = shift_q;
		idle_d   = idle_q;
		push.vld = 1'b0;
		push.row = hit.row;
		if (pulse_ticks == 8'd0) begin
			if (!idle_q) begin
				push.vld = accept && hit.vld;
				shift_d  = '0;
				idle_d   = 1'b1;
			end
		end else begin
			// tests act in order on the same width; the long drop wins
			priority if (is_long) begin
				shift_d = '0;
				idle_d  = 1'b1;
			end else if (is_one) begin
				shift_d = is_runt ? FRAME_BITS'(1) : {shift_q[FRAME_BITS-2:0], 1'b1};
				idle_d  = 1'b0;
			end else if (is_zero) begin
				shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
				idle_d  = 1'b0;
			end else if (is_runt) begin
				shift_d = '0;
				idle_d  = 1'b1;
			end else begin
				shift_d = shift_q;
				idle_d  = idle_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			idle_q  <= 1'b0;
		end else if (accept) begin
			shift_q <= shift_d;
			idle_q  <= idle_d;
		end
	end

endmodule

### rtl/pwfr_queue.sv
module pwfr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  pwfr_pkg::frame_ev_t push,
	input  logic                pop,
	output pwfr_pkg::frame_ev_t head,
	output pwfr_pkg::q_stat_t   q_stat
);
	import pwfr_pkg::*;

	row_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = count_q == QCNT_W'(QDEPTH);
	assign q_stat.empty = count_q == '0;
	assign head.vld     = !q_stat.empty;
	assign head.row     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wr_ptr_q] <= push.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.vld) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.vld && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.vld) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld |-> (!q_stat.full || pop))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("frame queue underflow");

endmodule

### rtl/pwfr_back.sv
module pwfr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pwfr_pkg::frame_ev_t head,
	output logic                pop,
	output logic                reply_valid,
	input  logic                reply_ready,
	output logic [23:0]         reply_word,
	output logic [4:0]          reply_top_bit,
	output logic                reply_last
);
	import pwfr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	row_t              row_q, sel_row;
	logic [WIDX_W-1:0] k_q, sel_k;
	logic              out_valid_q;
	logic              load, emit, sel_last;

	assign load = !out_valid_q || reply_ready;

	always_comb begin
		unique case (state_q)
			ST_RUN: begin
				sel_row = row_q;
				sel_k   = k_q;
				emit    = load;
				pop     = 1'b0;
			end
			default: begin
				sel_row = head.row;
				sel_k   = '0;
				emit    = load && head.vld;
				pop     = load && head.vld;
			end
		endcase
	end

	assign sel_last = (CNT_W'(sel_k) + 1'b1) == ROW_CNT[sel_row];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				row_q       <= sel_row;
				k_q         <= sel_k + 1'b1;
				state_q     <= sel_last ? ST_IDLE : ST_RUN;
			end else if (reply_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			reply_word    <= ROW_WORD[sel_row][sel_k];
			reply_top_bit <= ROW_TOP[sel_row][sel_k];
			reply_last    <= sel_last;
		end
	end

	assign reply_valid = out_valid_q;

	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q != '0 && CNT_W'(k_q) < ROW_CNT[row_q]))
		else $error("reply word index outside its row");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && load))
		else $error("frame popped while a reply run is in progress");

endmodule

### rtl/pulse_width_frame_responder.sv
// the row of a matched closing silence beat waits in the queue, which holds up to four
//   rows between front and back, until the back pops it and registers its first reply word
// throughput: one pulse beat per cycle while the queue is not full; replies leave at one
//   word per cycle from the output register while reply_ready is high
// reset: arst_n clears the frame (open, empty), the queue and the reply state at once, and
//   loads the thresholds with runt 5, one 50, long 220
module pulse_width_frame_responder (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_wr_en,
	input  logic [pwfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata,
	// pulse width beats
	input  logic                          pulse_valid,
	output logic                          pulse_ready,
	input  logic [7:0]                    pulse_ticks,
	// reply word beats
	output logic                          reply_valid,
	input  logic                          reply_ready,
	output logic [23:0]                   reply_word,
	output logic [4:0]                    reply_top_bit,
	output logic                          reply_last
);
	import pwfr_pkg::*;

	cfg_t      cfg_q;
	frame_ev_t push;
	frame_ev_t head;
	q_stat_t   q_stat;
	logic      pop;

	// threshold registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.runt_limit    <= RUNT_LIMIT_RST;
			cfg_q.one_threshold <= ONE_THRESHOLD_RST;
			cfg_q.long_limit    <= LONG_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RUNT_LIMIT:    cfg_q.runt_limit    <= cfg_wdata;
				CFG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_wdata;
				CFG_LONG_LIMIT:    cfg_q.long_limit    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: classify each width, shift bits into the frame, look up the
	// closed frame and queue the matching table row
	pwfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pulse_valid (pulse_valid),
		.pulse_ready (pulse_ready),
		.pulse_ticks (pulse_ticks),
		.q_stat      (q_stat),
		.push        (push)
	);

	// short queue of matched rows so the front keeps taking beats
	// while the back is still sending a reply run
	pwfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// back: walks the reply words of one row into the output register
	pwfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.reply_valid   (reply_valid),
		.reply_ready   (reply_ready),
		.reply_word    (reply_word),
		.reply_top_bit (reply_top_bit),
		.reply_last    (reply_last)
	);

endmodule

### verif/tb_pulse_width_frame_responder.sv
`timescale 1ns / 100ps

module tb_pulse_width_frame_responder;

	import pwfr_pkg::*;

	// index past the last threshold register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	// cycles with work pending but no beat moving before the run is called hung
	localparam int STALL_LIMIT = 4000;

	// frame words that have a reply, used to build well-formed frames
	localparam logic [31:0] KNOWN_FRAMES [11] = '{
		32'h0000_E704, 32'h0000_E70E, 32'h0000_E70D, 32'h0000_E716,
		32'h0000_E715, 32'h0000_E71A, 32'h0000_39C7, 32'h0000_E71C,
		32'h0000_E71F, 32'h0003_9B82, 32'h0000_0E72
	};

	typedef struct packed {
		logic [23:0] word;
		logic [4:0]  top_bit;
		logic        last;
	} reply_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_wdata = '0;
	logic                 pulse_valid = 1'b0;
	logic                 pulse_ready;
	logic [7:0]           pulse_ticks = '0;
	logic                 reply_valid;
	logic                 reply_ready = 1'b0;
	logic [23:0]          reply_word;
	logic [4:0]           reply_top_bit;
	logic                 reply_last;

	// pulse widths waiting to be driven, reply beats waiting to arrive
	logic [7:0]  pend_ticks [$];
	reply_beat_t replies_due [$];
	int          n_queued = 0;
	int          n_errors = 0;

	// local copy of the thresholds and the frame being assembled
	logic [7:0]            cfg_runt = RUNT_LIMIT_RST;
	logic [7:0]            cfg_one = ONE_THRESHOLD_RST;
	logic [7:0]            cfg_long = LONG_LIMIT_RST;
	logic [FRAME_BITS-1:0] fr_shift = '0;
	logic                  fr_idle = 1'b0;

	// handshake bookkeeping between the monitor and the driver
	logic pulse_took = 1'b0;
	int   quiet_cycles = 0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   stall_win = 0;
	logic [7:0] stall_mask = 8'hFF;
	logic [2:0] stall_phase = '0;

	pulse_width_frame_responder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pulse_valid  (pulse_valid),
		.pulse_ready  (pulse_ready),
		.pulse_ticks  (pulse_ticks),
		.reply_valid  (reply_valid),
		.reply_ready  (reply_ready),
		.reply_word   (reply_word),
		.reply_top_bit(reply_top_bit),
		.reply_last   (reply_last)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (n_errors < 50) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
		n_errors++;
	endtask

	// one pulse width through the frame logic; a closing silence queues the reply run
	task automatic advance_frame(input logic [7:0] w);
		logic [23:0] wd [4];
		logic [4:0]  tp [4];
		int          cnt;
		reply_beat_t rb;
		if (w != 8'd0) begin
			// the four tests act in order on the same width, odd thresholds can stack them
			if (w <= cfg_runt) begin
				fr_idle = 1'b1;
				fr_shift = '0;
			end
			if (w > cfg_runt && w < cfg_one) begin
				fr_idle = 1'b0;
				fr_shift = fr_shift << 1;
			end
			if (w >= cfg_one && w < cfg_long) begin
				fr_idle = 1'b0;
				fr_shift = (fr_shift << 1) | 1'b1;
			end
			if (w >= cfg_long) begin
				fr_idle = 1'b1;
				fr_shift = '0;
			end
		end else if (!fr_idle) begin
			cnt = 0;
			wd = '{default: '0};
			tp = '{default: '0};
			case (fr_shift)
				32'h0000_E704: begin
					cnt = 2;
					wd = '{24'hC31082, 24'hC3108B, 24'h0, 24'h0};
					tp = '{5'd23, 5'd23, 5'd0, 5'd0};
				end
				32'h0000_E70E, 32'h0000_E70D: begin
					cnt = 3;
					wd = '{24'h30C602, 24'h30C064, 24'h30C075, 24'h0};
					tp = '{5'd21, 5'd21, 5'd21, 5'd0};
				end
				32'h0000_E716: begin
					cnt = 4;
					wd = '{24'h30C692, 24'h0C301C, 24'h30C703, 24'h0C301F};
					tp = '{5'd21, 5'd19, 5'd21, 5'd19};
				end
				32'h0000_E715: begin
					cnt = 4;
					wd = '{24'h30C68A, 24'h0C301C, 24'h30C703, 24'h0C301F};
					tp = '{5'd21, 5'd19, 5'd21, 5'd19};
				end
				32'h0000_E71A: begin
					cnt = 3;
					wd = '{24'h30C613, 24'h0C301C, 24'h30C643, 24'h0};
					tp = '{5'd21, 5'd19, 5'd21, 5'd0};
				end
				32'h0000_39C7: begin
					cnt = 3;
					wd = '{24'h30C60B, 24'h0C301C, 24'h30C643, 24'h0};
					tp = '{5'd21, 5'd19, 5'd21, 5'd0};
				end
				32'h0000_E71C: begin
					cnt = 2;
					wd = '{24'h0C305D, 24'h30C643, 24'h0, 24'h0};
					tp = '{5'd19, 5'd21, 5'd0, 5'd0};
				end
				32'h0000_E71F: begin
					cnt = 1;
					wd = '{24'h030C26, 24'h0, 24'h0, 24'h0};
					tp = '{5'd17, 5'd0, 5'd0, 5'd0};
				end
				32'h0003_9B82: begin
					cnt = 1;
					wd = '{24'h0C309D, 24'h0, 24'h0, 24'h0};
					tp = '{5'd19, 5'd0, 5'd0, 5'd0};
				end
				32'h0000_0E72: begin
					cnt = 2;
					wd = '{24'h30C075, 24'h30C064, 24'h0, 24'h0};
					tp = '{5'd21, 5'd21, 5'd0, 5'd0};
				end
				default: cnt = 0;   // unknown word closes silently
			endcase
			for (int k = 0; k < cnt; k++) begin
				rb.word = wd[k];
				rb.top_bit = tp[k];
				rb.last = (k == cnt - 1);
				replies_due.push_back(rb);
			end
			fr_shift = '0;
			fr_idle = 1'b1;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic push_beat(input logic [7:0] w);
		pend_ticks.push_back(w);
		n_queued++;
	endtask

	// width for one data bit, hitting both range edges often
	function automatic logic [7:0] bit_width(input logic b);
		int lo, hi;
		lo = b ? int'(cfg_one) : int'(cfg_runt) + 1;
		hi = b ? int'(cfg_long) - 1 : int'(cfg_one) - 1;
		case ($urandom_range(0, 3))
			0: return 8'(lo);
			1: return 8'(hi);
			default: return 8'($urandom_range(hi, lo));
		endcase
	endfunction

	// width that throws the frame away, runt or over-long
	function automatic logic [7:0] drop_width();
		if (cfg_runt != 8'd0 && $urandom_range(0, 1)) begin
			return 8'($urandom_range(int'(cfg_runt), 1));
		end
		return 8'($urandom_range(255, int'(cfg_long)));
	endfunction

	// low n bits of a word, top bit first, then the closing silence
	task automatic push_frame(input logic [31:0] bits, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			push_beat(bit_width(bits[i]));
		end
		push_beat(8'd0);
	endtask

	// thresholds that leave a zero band and a one band with no overlap
	function automatic bit thresholds_clean();
		return (int'(cfg_runt) + 2 <= int'(cfg_one)) && (cfg_one < cfg_long);
	endfunction

	task automatic queue_random(input int budget);
		int          target, pick, klen, cut;
		logic [31:0] key;
		target = n_queued + budget;
		while (n_queued < target) begin
			pick = $urandom_range(0, 99);
			key = KNOWN_FRAMES[$urandom_range(0, 10)];
			klen = 0;
			for (int i = 0; i < 32; i++) begin
				if (key[i]) klen = i + 1;
			end
			if (!thresholds_clean() || pick >= 85) begin
				// noise, silence mixed in
				repeat ($urandom_range(1, 6)) begin
					push_beat(($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
				end
			end else if (pick < 40) begin
				// good frame, sometimes after a dropped pulse
				if ($urandom_range(0, 1)) push_beat(drop_width());
				push_frame(key, klen);
			end else if (pick < 50) begin
				// junk bits pushed off the top by a full-width good frame
				repeat ($urandom_range(1, 12)) push_beat(bit_width(1'($urandom_range(0, 1))));
				push_frame(key, FRAME_BITS);
			end else if (pick < 62) begin
				// damaged frame: one bit flipped or the tail missing
				if ($urandom_range(0, 1)) begin
					push_frame(key ^ (32'd1 << $urandom_range(0, klen - 1)), klen);
				end else begin
					cut = $urandom_range(1, klen - 1);
					push_frame(key >> cut, klen - cut);
				end
			end else if (pick < 70) begin
				// frame broken by a drop partway through
				cut = $urandom_range(1, klen - 1);
				for (int i = klen - 1; i >= cut; i--) push_beat(bit_width(key[i]));
				push_beat(drop_width());
				if ($urandom_range(0, 1)) push_frame(key, cut);
				else push_beat(8'd0);
			end else begin
				push_frame(32'($urandom), $urandom_range(1, 20));
			end
		end
	endtask

	// block idle: nothing left to send, nothing due, then a pause for unmatched frames
	task automatic settle();
		while (pend_ticks.size() != 0 || pulse_valid || replies_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_RUNT_LIMIT:    cfg_runt = data;
			CFG_ONE_THRESHOLD: cfg_one = data;
			CFG_LONG_LIMIT:    cfg_long = data;
			default: ;         // no register there
		endcase
	endtask

	task automatic set_thresholds(input int r, input int o, input int l);
		settle();
		write_reg(CFG_NO_REG, 8'($urandom));
		write_reg(CFG_RUNT_LIMIT, 8'(r));
		write_reg(CFG_ONE_THRESHOLD, 8'(o));
		write_reg(CFG_LONG_LIMIT, 8'(l));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------- pulse driver ----------------

	// new beat only once the held one has gone; bursts with random gaps
	always @(negedge clk) begin : pulse_driver
		if (!pulse_valid || pulse_took) begin
			if (arst_n && gap_left == 0 && pend_ticks.size() != 0) begin
				pulse_valid <= 1'b1;
				pulse_ticks <= pend_ticks.pop_front();
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
					                                          : $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				pulse_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	// ---------------- reply back-pressure ----------------

	// an 8-bit ready mask, stepped through in a loop and replaced at random, sometimes all ones
	always @(negedge clk) begin : reply_stall
		if (stall_win == 0) begin
			stall_win = $urandom_range(16, 80);
			stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(255, 1));
		end
		stall_win--;
		stall_phase = stall_phase + 3'd1;
		reply_ready <= stall_mask[stall_phase];
	end

	// ---------------- monitor, predictor and watchdog ----------------

	always @(posedge clk) begin : beat_monitor
		reply_beat_t due;
		pulse_took <= arst_n && pulse_valid && pulse_ready;
		if (arst_n) begin
			// replies are checked before this edge's pulse can add expectations
			if (reply_valid && reply_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("reply beat %h with nothing due", reply_word));
				end else begin
					due = replies_due.pop_front();
					if (reply_word !== due.word)
						report_mismatch($sformatf("reply_word %h, want %h", reply_word, due.word));
					if (reply_top_bit !== due.top_bit)
						report_mismatch($sformatf("reply_top_bit %0d, want %0d",
						                          reply_top_bit, due.top_bit));
					if (reply_last !== due.last)
						report_mismatch($sformatf("reply_last %b, want %b", reply_last, due.last));
				end
			end
			if (pulse_valid && pulse_ready) advance_frame(pulse_ticks);

			// hang check: work pending but no beat moving
			if ((pulse_valid && pulse_ready) || (reply_valid && reply_ready) ||
			    (!pulse_valid && replies_due.size() == 0)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: silence on the empty frame after reset, drops at the extremes and
		// the limits, silence on an idle frame, a short good frame, an unknown one
		push_beat(8'd0);
		push_beat(8'd1);
		push_beat(8'd0);
		push_beat(8'd255);
		push_beat(cfg_runt);
		push_beat(cfg_long);
		push_frame(32'h0000_0E72, 12);
		push_beat(8'd0);
		push_frame(32'h0000_0005, 3);

		// reset thresholds
		queue_random(150);

		// widest bands: no runt drop, only 255 is too long
		set_thresholds(0, 128, 255);
		queue_random(60);

		// everything drops at both ends of the register range
		set_thresholds(255, 255, 255);
		queue_random(15);
		set_thresholds(0, 0, 0);
		queue_random(10);

		// overlapping tests: runt drop followed by a one bit on the same width
		set_thresholds(100, 40, 200);
		queue_random(25);

		// overlapping tests: zero bit followed by a long drop on the same width
		set_thresholds(20, 120, 60);
		queue_random(25);

		// one-wide zero and one bands
		set_thresholds(0, 2, 3);
		queue_random(40);

		// two random clean settings
		repeat (2) begin
			int r, o, l;
			r = $urandom_range(0, 80);
			o = $urandom_range(160, r + 2);
			l = $urandom_range(255, o + 1);
			set_thresholds(r, o, l);
			queue_random(35);
		end

		settle();
		repeat (20) @(negedge clk);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
